[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries concurrent checks.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SXF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define SXF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SXF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SXF_ASSERT_ALWAYS(lbl, cond, msg)
`define SXF_ASSERT_SAME(lbl, ante, cons, msg)
`define SXF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/sxf_pkg.sv]
// Package for the stereo crossfeed FIR: widths, coefficient tables, the
// controller state type, the command struct and the saturation helper.
// No dependencies.
package sxf_pkg;

  localparam int TAP_COUNT  = 32;
  localparam int TAP_W      = $clog2(TAP_COUNT);
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 6;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = 24;
  localparam int FIR_SHIFT  = 7;
  localparam int SHIFTED_W  = ACC_W - FIR_SHIFT;

  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);

  localparam logic signed [COEF_W-1:0] COEF_A [TAP_COUNT] = '{
     6'sd4,   6'sd4,  -6'sd1,   6'sd3,  -6'sd2,  -6'sd5,   6'sd9,   6'sd6,
    -6'sd4,  -6'sd5,  -6'sd2,  -6'sd7,   6'sd6,   6'sd30,  6'sd12, -6'sd11,
    -6'sd3,  -6'sd20,  6'sd2,   6'sd1,  -6'sd14,  6'sd15,  6'sd6,   6'sd15,
    -6'sd14, -6'sd7,  -6'sd4,   6'sd6,   6'sd6,   6'sd0,   6'sd0,   6'sd4
  };

  localparam logic signed [COEF_W-1:0] COEF_B [TAP_COUNT] = '{
    -6'sd6,  -6'sd11, -6'sd5,   6'sd3,   6'sd5,   6'sd0,   6'sd1,   6'sd3,
    -6'sd1,  -6'sd3,  -6'sd5,   6'sd1,  -6'sd7,  -6'sd29, -6'sd3,   6'sd4,
     6'sd7,   6'sd23,  6'sd0,  -6'sd6,  -6'sd5,  -6'sd18,  6'sd7,  -6'sd10,
     6'sd22, -6'sd2,   6'sd9,  -6'sd12, -6'sd6,  -6'sd11, -6'sd5,   6'sd0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_PUSH,
    ST_EMIT
  } sxf_state_t;

  typedef struct packed {
    logic             load;
    logic             mac;
    logic             push;
    logic             emit;
    logic             bypass;
    logic [TAP_W-1:0] tap;
  } sxf_cmd_t;

  // Saturates a 17-bit signed value to the 16-bit sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat17(logic signed [SAMPLE_W:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
      r = v[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/sxf_if.sv]
// Stream interfaces for the stereo crossfeed FIR: input sample pairs and
// output mix pairs, each with a valid/ready handshake. Depends on sxf_pkg.
interface sxf_in_if
  import sxf_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source(output valid, output left_sample, output right_sample, input ready);
  modport sink(input valid, input left_sample, input right_sample, output ready);
endinterface

interface sxf_out_if
  import sxf_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  modport source(output valid, output left_out, output right_out, input ready);
  modport sink(input valid, input left_out, input right_out, output ready);
endinterface

[hw/rtl/sxf_ctrl.sv]
// Controller for the stereo crossfeed FIR: sequences load, the tap loop,
// the history push and the output transaction; holds the bypass register.
// Depends on sxf_pkg.
module sxf_ctrl
  import sxf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output sxf_cmd_t cmd
);

  sxf_state_t       state, state_next;
  logic [TAP_W-1:0] tap, tap_next;
  logic             out_valid_next;
  logic             bypass;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap       <= '0;
      out_valid <= 1'b0;
      bypass    <= 1'b0;
    end else begin
      state     <= state_next;
      tap       <= tap_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        bypass <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_next = state;
    tap_next   = tap;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.bypass = bypass;
    cmd.tap    = tap;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        tap_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bypass ? ST_PUSH : ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac  = 1'b1;
        tap_next = tap + 1'b1;
        if (tap == TAP_LAST) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

[hw/rtl/sxf_dp.sv]
// Datapath for the stereo crossfeed FIR: rotating sample histories, four
// multiply-accumulate lanes, final shift, saturation and the output register.
// Depends on sxf_pkg.
module sxf_dp
  import sxf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  sxf_cmd_t                   cmd,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  output logic signed [SAMPLE_W-1:0] left_out,
  output logic signed [SAMPLE_W-1:0] right_out
);

  logic signed [SAMPLE_W-1:0] hist_l [TAP_COUNT];
  logic signed [SAMPLE_W-1:0] hist_r [TAP_COUNT];
  logic signed [SAMPLE_W-1:0] cur_l, cur_r;
  logic signed [ACC_W-1:0]    acc_la, acc_lb, acc_ra, acc_rb;
  logic signed [PROD_W-1:0]   prod_la, prod_lb, prod_ra, prod_rb;
  logic signed [SAMPLE_W-1:0] fir_la, fir_lb, fir_ra, fir_rb;
  logic signed [SAMPLE_W-1:0] mix_l, mix_r;

  // The oldest sample sits at entry 0; each tap step rotates the history by
  // one so that entry 0 always holds the sample for the current tap.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        hist_l[i] <= '0;
        hist_r[i] <= '0;
      end
    end else if (cmd.mac || cmd.push) begin
      for (int i = 0; i < TAP_COUNT - 1; i++) begin
        hist_l[i] <= hist_l[i+1];
        hist_r[i] <= hist_r[i+1];
      end
      hist_l[TAP_COUNT-1] <= cmd.push ? cur_l : hist_l[0];
      hist_r[TAP_COUNT-1] <= cmd.push ? cur_r : hist_r[0];
    end
  end

  assign prod_la = hist_l[0] * COEF_A[cmd.tap];
  assign prod_lb = hist_l[0] * COEF_B[cmd.tap];
  assign prod_ra = hist_r[0] * COEF_A[cmd.tap];
  assign prod_rb = hist_r[0] * COEF_B[cmd.tap];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_l  <= left_sample;
      cur_r  <= right_sample;
      acc_la <= '0;
      acc_lb <= '0;
      acc_ra <= '0;
      acc_rb <= '0;
    end else if (cmd.mac) begin
      acc_la <= acc_la + ACC_W'(prod_la);
      acc_lb <= acc_lb + ACC_W'(prod_lb);
      acc_ra <= acc_ra + ACC_W'(prod_ra);
      acc_rb <= acc_rb + ACC_W'(prod_rb);
    end
  end

  // Dropping the low bits of a signed value is a shift that rounds down.
  assign fir_la = sat17($signed(acc_la[ACC_W-1:FIR_SHIFT]));
  assign fir_lb = sat17($signed(acc_lb[ACC_W-1:FIR_SHIFT]));
  assign fir_ra = sat17($signed(acc_ra[ACC_W-1:FIR_SHIFT]));
  assign fir_rb = sat17($signed(acc_rb[ACC_W-1:FIR_SHIFT]));

  assign mix_l = sat17((SAMPLE_W+1)'(fir_lb) + (SAMPLE_W+1)'(fir_ra));
  assign mix_r = sat17((SAMPLE_W+1)'(fir_la) + (SAMPLE_W+1)'(fir_rb));

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      left_out  <= cmd.bypass ? cur_l : mix_l;
      right_out <= cmd.bypass ? cur_r : mix_r;
    end
  end

endmodule

[hw/rtl/stereo_crossfeed_fir.sv]
// Top level of the stereo crossfeed FIR: joins the controller and the
// datapath to the stream interfaces. Depends on sxf_pkg, sxf_if, sxf_ctrl,
// sxf_dp and assert_macros.svh.
//
//   Port       Direction  Payload
//   sample_ch  sink       left_sample, right_sample (signed 16-bit)
//   mix_ch     source     left_out, right_out (signed 16-bit)
//   cfg_we     input      writes cfg_wdata into the bypass register
//
// A filtered transaction loads the sample pair, runs the tap loop of the four
// multiply-accumulate lanes, pushes the history and loads the output register.
// A bypass transaction skips the tap loop but still pushes the history.
// Reset clears the histories, the bypass register and all control state.
// A waiting result holds the output register; the next transaction is taken
// meanwhile and its tap loop runs, stalling only before its own output load.
`include "assert_macros.svh"

module stereo_crossfeed_fir
  import sxf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  sxf_in_if.sink           sample_ch,
  sxf_out_if.source        mix_ch,
  input  logic             cfg_we,
  input  logic             cfg_wdata
);

  sxf_cmd_t cmd;

  sxf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (mix_ch.valid),
    .out_ready (mix_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd)
  );

  sxf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .left_sample  (sample_ch.left_sample),
    .right_sample (sample_ch.right_sample),
    .left_out     (mix_ch.left_out),
    .right_out    (mix_ch.right_out)
  );

  `SXF_ASSERT_SAME(a_no_accept_busy, cmd.mac || cmd.push, !sample_ch.ready, "Input taken while busy.")
  `SXF_ASSERT_SAME(a_emit_slot_free, cmd.emit, !mix_ch.valid || mix_ch.ready, "Result overwritten.")
  `SXF_ASSERT_NEXT(a_filter_starts, sample_ch.valid && sample_ch.ready && !cmd.bypass, cmd.mac && cmd.tap == '0, "Tap loop did not start.")
  `SXF_ASSERT_NEXT(a_push_after_loop, cmd.mac && cmd.tap == TAP_LAST, cmd.push, "History push missed.")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for stereo_crossfeed_fir: directed and random stereo sample
// transactions, with the crossfeed mix predicted in the bench and compared per result.
// Depends on sxf_pkg, the sxf_in_if/sxf_out_if interfaces and the RTL of the block.
module tb_top;
  import sxf_pkg::*;

  localparam int TAPS = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PAIRS = 119;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t left;
    sample_t right;
  } mix_pair_t;

  typedef struct {
    bit      cfg_write;
    bit      cfg_value;
    sample_t left;
    sample_t right;
    bit      known;
    sample_t want_left;
    sample_t want_right;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  sxf_in_if  sample_if ();
  sxf_out_if mix_if ();

  stereo_crossfeed_fir DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_if),
    .mix_ch    (mix_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  int coef_a [TAPS] = '{
      4,   4,  -1,   3,  -2,  -5,   9,   6,  -4,  -5,  -2,  -7,   6,  30,  12, -11,
     -3, -20,   2,   1, -14,  15,   6,  15, -14,  -7,  -4,   6,   6,   0,   0,   4
  };
  int coef_b [TAPS] = '{
     -6, -11,  -5,   3,   5,   0,   1,   3,  -1,  -3,  -5,   1,  -7, -29,  -3,   4,
      7,  23,   0,  -6,  -5, -18,   7, -10,  22,  -2,   9, -12,  -6, -11,   -5,  0
  };

  sample_t   hist_l [TAPS];
  sample_t   hist_r [TAPS];
  bit        bypass_mode;
  mix_pair_t expected_mix [$];
  stim_row_t directed_rows [$];
  bit        calm;
  int        mismatches;
  int        pairs_sent;
  int        mix_results;
  int        clipped_results;
  int        bypass_writes;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic sample_t clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return sample_t'(v);
  endfunction

  function automatic sample_t fir_tap(bit right_ch, bit use_b);
    int acc;
    acc = 0;
    for (int i = 0; i < TAPS; i++) begin
      acc += int'(right_ch ? hist_r[i] : hist_l[i]) * (use_b ? coef_b[i] : coef_a[i]);
    end
    return clip16(acc >>> 7);
  endfunction

  function automatic mix_pair_t mix_predict(sample_t l, sample_t r);
    mix_pair_t p;
    sample_t   la;
    sample_t   lb;
    sample_t   ra;
    sample_t   rb;
    if (bypass_mode) begin
      p.left = l;
      p.right = r;
    end else begin
      la = fir_tap(1'b0, 1'b0);
      lb = fir_tap(1'b0, 1'b1);
      ra = fir_tap(1'b1, 1'b0);
      rb = fir_tap(1'b1, 1'b1);
      p.left = clip16(int'(lb) + int'(ra));
      p.right = clip16(int'(la) + int'(rb));
    end
    for (int i = 0; i < TAPS - 1; i++) begin
      hist_l[i] = hist_l[i + 1];
      hist_r[i] = hist_r[i + 1];
    end
    hist_l[TAPS - 1] = l;
    hist_r[TAPS - 1] = r;
    return p;
  endfunction

  function automatic void add_row(bit cw, bit cv, int l, int r,
                                  bit known = 1'b0, int wl = 0, int wr = 0);
    stim_row_t row;
    row.cfg_write = cw;
    row.cfg_value = cv;
    row.left = sample_t'(l);
    row.right = sample_t'(r);
    row.known = known;
    row.want_left = sample_t'(wl);
    row.want_right = sample_t'(wr);
    directed_rows.push_back(row);
  endfunction

  function automatic sample_t pick_edge();
    case ($urandom_range(4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  // Sample whose sign matches the coefficient (opposite when neg is set), so that a full
  // run of them lines the history up with the taps and drives the sum into clipping.
  function automatic sample_t aligned_sample(int c, bit neg);
    if (c == 0) return sample_t'($urandom);
    return ((c > 0) ^ neg) ? 16'sd32767 : -16'sd32768;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s at %0t: got %0d, expected %0d", what, $time, got, want);
    mismatches++;
  endtask

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic put_pair(sample_t l, sample_t r);
    while (!calm && $urandom_range(99) < 7) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.left_sample <= l;
    sample_if.right_sample <= r;
    do @(posedge clk); while (!sample_if.ready);
  endtask

  task automatic set_bypass(bit v);
    sample_if.valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bypass_mode = v;
    bypass_writes++;
  endtask

  always @(posedge clk) begin
    mix_if.ready <= calm || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin : mix_check
    mix_pair_t want;
    if (!rst && mix_if.valid && mix_if.ready) begin
      mix_results++;
      if (mix_if.left_out == 16'sh7fff || mix_if.left_out == 16'sh8000 ||
          mix_if.right_out == 16'sh7fff || mix_if.right_out == 16'sh8000) begin
        clipped_results++;
      end
      if (expected_mix.size() == 0) begin
        report_mismatch("unexpected result, left_out", mix_if.left_out, 0);
      end else begin
        want = expected_mix.pop_front();
        if (mix_if.left_out !== want.left) begin
          report_mismatch("left_out", mix_if.left_out, want.left);
        end
        if (mix_if.right_out !== want.right) begin
          report_mismatch("right_out", mix_if.right_out, want.right);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", expected_mix.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    mix_pair_t pred;
    sample_t   l;
    sample_t   r;
    int        run_pos;
    bit        run_neg;
    int        kind;
    bit        phase_bypass [RANDOM_PHASES];

    phase_bypass = '{0, 1, 0, 0, 1, 1, 0, 0};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    sample_if.valid <= 1'b0;
    sample_if.left_sample <= '0;
    sample_if.right_sample <= '0;
    calm = 1'b0;
    bypass_mode = 1'b0;
    run_pos = -1;
    run_neg = 1'b0;
    for (int i = 0; i < TAPS; i++) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end

    add_row(0, 0, 0, 0, 1, 0, 0);
    add_row(0, 0, 32767, -32768, 1, 0, 0);
    add_row(0, 0, 0, 0);
    add_row(0, 0, 0, 0);
    add_row(0, 0, -1, 1);
    add_row(0, 0, 0, 0);
    add_row(0, 0, 1, -1);
    add_row(0, 0, 32767, 32767);
    add_row(0, 0, 32767, 32767);
    add_row(0, 0, -32768, -32768);
    add_row(0, 0, -32768, 32767);
    add_row(0, 0, 32767, -32768);
    add_row(0, 0, 0, 0);
    add_row(1, 1, 32767, -32768, 1, 32767, -32768);
    add_row(0, 0, -32768, 32767, 1, -32768, 32767);
    add_row(0, 0, 21845, -21846, 1, 21845, -21846);
    add_row(0, 0, -1, 0, 1, -1, 0);
    add_row(1, 0, 0, 0);
    add_row(0, 0, 0, 0);
    add_row(0, 0, 100, -100);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_write) begin
        set_bypass(directed_rows[i].cfg_value);
      end
      put_pair(directed_rows[i].left, directed_rows[i].right);
      pred = mix_predict(directed_rows[i].left, directed_rows[i].right);
      if (directed_rows[i].known) begin
        pred.left = directed_rows[i].want_left;
        pred.right = directed_rows[i].want_right;
      end
      expected_mix.push_back(pred);
      pairs_sent++;
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_bypass(phase_bypass[ph]);
      calm = (ph == 3);
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        if (run_pos < 0 && $urandom_range(99) < 4) begin
          run_pos = 0;
          run_neg = $urandom_range(1);
        end
        if (run_pos >= 0) begin
          l = aligned_sample(coef_b[run_pos], run_neg);
          r = aligned_sample(coef_a[run_pos], run_neg);
          run_pos = (run_pos == TAPS - 1) ? -1 : run_pos + 1;
        end else begin
          kind = $urandom_range(99);
          if (kind < 55) begin
            l = sample_t'($urandom);
            r = sample_t'($urandom);
          end else if (kind < 75) begin
            l = pick_edge();
            r = pick_edge();
          end else begin
            l = sample_t'($urandom_range(127)) - 16'sd64;
            r = sample_t'($urandom_range(127)) - 16'sd64;
          end
        end
        put_pair(l, r);
        expected_mix.push_back(mix_predict(l, r));
        pairs_sent++;
      end
    end
    calm = 1'b0;

    sample_if.valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d sample pairs (%0d directed) over %0d bypass writes; %0d results checked.",
             pairs_sent, directed_rows.size(), bypass_writes, mix_results);
    $display("%0d results reached the clip limits; %0d mismatches.",
             clipped_results, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sxf_pkg.sv
hw/rtl/sxf_if.sv
hw/rtl/sxf_ctrl.sv
hw/rtl/sxf_dp.sv
hw/rtl/stereo_crossfeed_fir.sv
bench/tb_top.sv
